// ----- rtl/csv_fs_pkg.sv -----
// csv_fs_pkg: shared types and constants of the csv field splitter
// used by the channel interfaces, the top level and its checker
`timescale 1ns / 1ps

package csv_fs_pkg;

  localparam int CHAR_W              = 8;
  localparam int MAX_FIELDS_W        = 10;
  localparam int FIELD_INDEX_MAX_DEF = 1023;

  // apb register map, register i at byte address 4*i
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_SEPARATOR  = 2'd0;
  localparam logic [1:0] REG_QUOTE      = 2'd1;
  localparam logic [1:0] REG_MAX_FIELDS = 2'd2;

  localparam logic [CHAR_W-1:0]       SEPARATOR_RST  = 8'd44;
  localparam logic [CHAR_W-1:0]       QUOTE_RST      = 8'd34;
  localparam logic [MAX_FIELDS_W-1:0] MAX_FIELDS_RST = '0;

  localparam logic FUNC_CHAR = 1'b0;
  localparam logic FUNC_EOL  = 1'b1;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_PLAIN  = 2'd1,
    MODE_QUOTED = 2'd2,
    MODE_DROP   = 2'd3
  } mode_t;

endpackage

// ----- rtl/csv_in_if.sv -----
// csv_in_if: valid/ready channel carrying one line character or end of line
// depends on csv_fs_pkg
`timescale 1ns / 1ps

interface csv_in_if;
  import csv_fs_pkg::*;

  logic              valid;
  logic              ready;
  logic              func;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output func, output char_code, input ready);
  modport sink (input valid, input func, input char_code, output ready);
endinterface

// ----- rtl/csv_out_if.sv -----
// csv_out_if: valid/ready channel carrying field characters and field ends
// depends on csv_fs_pkg
`timescale 1ns / 1ps

interface csv_out_if #(
  parameter int IDX_W = 10
);
  import csv_fs_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [CHAR_W-1:0] out_char;
  logic [IDX_W-1:0]  field_index;
  logic              last_field;

  modport source (output valid, output kind, output out_char, output field_index,
                  output last_field, input ready);
  modport sink (input valid, input kind, input out_char, input field_index,
                input last_field, output ready);
endinterface

// ----- rtl/csv_field_splitter.sv -----
// csv_field_splitter: streaming csv line splitter with apb configuration
// depends on csv_fs_pkg, csv_in_if and csv_out_if
`timescale 1ns / 1ps

// Takes one beat per cycle on char_in (a line character, or end of line)
// while char_in is ready, and answers with at most one beat on field_out: a
// field character, or a field end with its index and a flag for the end that
// closes the line. A field opening with the quote byte is quoted; doubled
// quotes inside it yield one quote and the separator ends it only after a
// closing quote. An accepted beat passes the single parse stage between the
// input and the output register; the result is registered there, or in the
// skid behind a stalled beat. A two-deep output stage (output register plus
// skid) keeps char_in ready while one result waits, so a stalled sink stops
// input only once two results are pending. The field index saturates at
// FIELD_INDEX_MAX. Registers (apb, byte address 4*i): separator (0), quote
// (1), max fields (2, 0 = no limit); write them only while the block is idle.
module csv_field_splitter #(
  parameter int FIELD_INDEX_MAX = csv_fs_pkg::FIELD_INDEX_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [csv_fs_pkg::PADDR_W-1:0]  paddr,
  input  logic [csv_fs_pkg::PDATA_W-1:0]  pwdata,
  output logic [csv_fs_pkg::PDATA_W-1:0]  prdata,
  output logic                            pready,
  csv_in_if.sink                          char_in,
  csv_out_if.source                       field_out
);
  import csv_fs_pkg::*;

  localparam int IDX_W = $clog2(FIELD_INDEX_MAX + 1);
  localparam int CMP_W = (IDX_W > MAX_FIELDS_W) ? IDX_W : MAX_FIELDS_W;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(FIELD_INDEX_MAX);

  // configuration registers
  logic [CHAR_W-1:0]       separator_char;
  logic [CHAR_W-1:0]       quote_char;
  logic [MAX_FIELDS_W-1:0] max_fields;

  // parser state
  mode_t            parse_mode, parse_mode_next;
  logic             quote_toggle, quote_toggle_next;
  logic [IDX_W-1:0] field_count, field_count_next;
  logic             line_nonempty, line_nonempty_next;

  // output register and skid
  logic              out_valid;
  logic              out_kind;
  logic [CHAR_W-1:0] out_chr;
  logic [IDX_W-1:0]  out_idx;
  logic              out_last;
  logic              skid_valid;
  logic              skid_kind;
  logic [CHAR_W-1:0] skid_chr;
  logic [IDX_W-1:0]  skid_idx;
  logic              skid_last;

  // result of the current beat
  logic              gen;
  logic              res_kind;
  logic [CHAR_W-1:0] res_chr;
  logic              res_last;

  logic             accept;
  logic [IDX_W-1:0] count_inc;
  logic             hit;
  logic             cfg_wr;
  logic [1:0]       cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      separator_char <= SEPARATOR_RST;
      quote_char     <= QUOTE_RST;
      max_fields     <= MAX_FIELDS_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SEPARATOR:  separator_char <= pwdata[CHAR_W-1:0];
        REG_QUOTE:      quote_char     <= pwdata[CHAR_W-1:0];
        REG_MAX_FIELDS: max_fields     <= pwdata[MAX_FIELDS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SEPARATOR:  prdata = PDATA_W'(separator_char);
      REG_QUOTE:      prdata = PDATA_W'(quote_char);
      REG_MAX_FIELDS: prdata = PDATA_W'(max_fields);
      default:        prdata = '0;
    endcase
  end

  assign char_in.ready = !skid_valid;
  assign accept        = char_in.valid && !skid_valid;

  // saturating count of the field being closed, and the field limit test
  assign count_inc = (field_count < IDX_MAX) ? field_count + 1'b1 : field_count;
  assign hit = (max_fields != '0) && (CMP_W'(count_inc) == CMP_W'(max_fields));

  always_comb begin
    parse_mode_next    = parse_mode;
    quote_toggle_next  = quote_toggle;
    field_count_next   = field_count;
    line_nonempty_next = line_nonempty;
    gen                = 1'b0;
    res_kind           = KIND_CHAR;
    res_chr            = char_in.char_code;
    res_last           = 1'b0;

    if (char_in.func == FUNC_EOL) begin
      gen                = line_nonempty && (parse_mode != MODE_DROP);
      res_kind           = KIND_END;
      res_chr            = '0;
      res_last           = 1'b1;
      parse_mode_next    = MODE_START;
      quote_toggle_next  = 1'b0;
      field_count_next   = '0;
      line_nonempty_next = 1'b0;
    end else begin
      line_nonempty_next = 1'b1;
      case (parse_mode)
        MODE_START: begin
          if (char_in.char_code == quote_char) begin
            parse_mode_next   = MODE_QUOTED;
            quote_toggle_next = 1'b0;
          end else if (char_in.char_code == separator_char) begin
            gen               = 1'b1;
            res_kind          = KIND_END;
            res_chr           = '0;
            res_last          = hit;
            field_count_next  = count_inc;
            quote_toggle_next = 1'b0;
            parse_mode_next   = hit ? MODE_DROP : MODE_START;
          end else begin
            gen             = 1'b1;
            parse_mode_next = MODE_PLAIN;
          end
        end
        MODE_PLAIN: begin
          gen = 1'b1;
          if (char_in.char_code == separator_char) begin
            res_kind          = KIND_END;
            res_chr           = '0;
            res_last          = hit;
            field_count_next  = count_inc;
            quote_toggle_next = 1'b0;
            parse_mode_next   = hit ? MODE_DROP : MODE_START;
          end
        end
        MODE_QUOTED: begin
          if (char_in.char_code == quote_char) begin
            // second quote of a pair is the literal one
            gen               = quote_toggle;
            quote_toggle_next = !quote_toggle;
          end else if (char_in.char_code == separator_char && quote_toggle) begin
            gen               = 1'b1;
            res_kind          = KIND_END;
            res_chr           = '0;
            res_last          = hit;
            field_count_next  = count_inc;
            quote_toggle_next = 1'b0;
            parse_mode_next   = hit ? MODE_DROP : MODE_START;
          end else begin
            gen = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode    <= MODE_START;
      quote_toggle  <= 1'b0;
      field_count   <= '0;
      line_nonempty <= 1'b0;
    end else if (accept) begin
      parse_mode    <= parse_mode_next;
      quote_toggle  <= quote_toggle_next;
      field_count   <= field_count_next;
      line_nonempty <= line_nonempty_next;
    end
  end

  // output register with skid: a new result parks in the skid only while
  // the output register holds a stalled beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !field_out.ready) begin
      if (accept && gen) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= accept && gen;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !field_out.ready) begin
      if (accept && gen) begin
        skid_kind <= res_kind;
        skid_chr  <= res_chr;
        skid_idx  <= field_count;
        skid_last <= res_last;
      end
    end else if (skid_valid) begin
      out_kind <= skid_kind;
      out_chr  <= skid_chr;
      out_idx  <= skid_idx;
      out_last <= skid_last;
    end else if (accept && gen) begin
      out_kind <= res_kind;
      out_chr  <= res_chr;
      out_idx  <= field_count;
      out_last <= res_last;
    end
  end

  assign field_out.valid       = out_valid;
  assign field_out.kind        = out_kind;
  assign field_out.out_char    = out_chr;
  assign field_out.field_index = out_idx;
  assign field_out.last_field  = out_last;

endmodule

// ----- rtl/csv_fs_check.sv -----
// csv_fs_check: port-level assertions for csv_field_splitter, bound to it
// depends on csv_fs_pkg and csv_field_splitter
`timescale 1ns / 1ps

module csv_fs_check (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_kind,
  input logic out_last,
  input logic [csv_fs_pkg::CHAR_W-1:0] out_char
);
  import csv_fs_pkg::*;

  // a pending output beat stays up until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  a_rst_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // only a field end can close the line
  a_last_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_CHAR |-> !out_last)
    else $error("last field flag on a field character");

  a_end_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_END |-> out_char == '0)
    else $error("field end carries a character");

  // input side stalls only while the output side is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && $past(out_valid && !out_ready))
    else $error("input stalled without a pending output");

endmodule

bind csv_field_splitter csv_fs_check u_csv_fs_check (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (char_in.ready),
  .out_valid (field_out.valid),
  .out_ready (field_out.ready),
  .out_kind  (field_out.kind),
  .out_last  (field_out.last_field),
  .out_char  (field_out.out_char)
);
